FILE: src/owps_pkg.sv
package owps_pkg;

  // queue of bytes waiting to go out on the wire
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueueAw     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitIdxW     = $clog2(BitsPerByte);
  localparam int unsigned TickW       = 10;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 10;

  // request codes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SEND     = 2'd1;
  localparam logic [1:0] OP_COMBINED = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_START_HIGH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_START_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHORT      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BUSY_WAIT  = 3'd4;

  // register reset values
  localparam logic [TickW-1:0] START_HIGH_RST = 10'd1;
  localparam logic [TickW-1:0] START_LOW_RST  = 10'd30;
  localparam logic [TickW-1:0] LONG_RST       = 10'd15;
  localparam logic [TickW-1:0] SHORT_RST      = 10'd5;

  // leading byte of a combined send
  localparam logic [7:0] LEAD_BYTE = 8'h0a;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_WAIT       = 6'b000010,
    PH_START_HIGH = 6'b000100,
    PH_START_LOW  = 6'b001000,
    PH_BIT_HIGH   = 6'b010000,
    PH_BIT_LOW    = 6'b100000
  } owps_phase_e;

  typedef struct packed {
    logic [TickW-1:0] start_high_ticks;
    logic [TickW-1:0] start_low_ticks;
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] short_ticks;
    logic             busy_wait_enable;
  } owps_cfg_t;

  typedef struct packed {
    logic line_level;
    logic idle;
    logic rejected;
  } owps_result_t;

  // a duration of zero counts as one tick
  function automatic logic [TickW-1:0] dur(input logic [TickW-1:0] d);
    dur = (d == '0) ? TickW'(1) : d;
  endfunction

endpackage

FILE: src/owps_core.sv
module owps_core import owps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [1:0]   operation_i,
  input  logic [7:0]   command_code_i,
  input  logic [7:0]   number_i,
  input  logic         module_busy_i,
  input  owps_cfg_t    cfg_i,
  output owps_result_t res_o
);

  owps_phase_e          phase_q, phase_d;
  logic [TickW-1:0]     tick_left_q, tick_left_d;
  logic [BitIdxW-1:0]   bit_index_q, bit_index_d;
  logic [7:0]           shift_byte_q, shift_byte_d;
  logic [QueueCntW-1:0] queue_count_q, queue_count_d;
  logic [QueueAw-1:0]   queue_head_q, queue_head_d;
  logic [7:0]           queue_q [QueueDepth];

  logic                 is_send, was_idle, rejected, do_enq;
  logic [7:0]           seq [QueueDepth];
  logic [QueueCntW-1:0] seq_len;
  logic [15:0]          prod;
  logic [7:0]           quot, tens, rem;
  logic [QueueAw-1:0]   off [QueueDepth];
  logic [7:0]           next_shift;
  logic [TickW-1:0]     high_dur, next_high_dur, low_dur;

  // decimal split by reciprocal multiply, exact for 8-bit numbers
  assign prod = 16'(number_i) * 16'd205;
  assign quot = 8'(prod[15:11]);
  assign tens = 8'(quot << 3) + 8'(quot << 1);
  assign rem  = number_i - tens;

  always_comb begin
    for (int i = 0; i < QueueDepth; i++) seq[i] = '0;
    if (operation_i == OP_SEND) begin
      seq[0]  = command_code_i;
      seq_len = QueueCntW'(1);
    end else if (number_i < 8'd10) begin
      seq[0]  = LEAD_BYTE;
      seq[1]  = number_i;
      seq[2]  = command_code_i;
      seq_len = QueueCntW'(3);
    end else begin
      seq[0]  = LEAD_BYTE;
      seq[1]  = quot;
      seq[2]  = rem;
      seq[3]  = command_code_i;
      seq_len = QueueCntW'(4);
    end
  end

  assign is_send  = (operation_i == OP_SEND) || (operation_i == OP_COMBINED);
  assign was_idle = (phase_q == PH_IDLE) && (queue_count_q == '0);
  assign rejected = is_send && !was_idle;
  assign do_enq   = accept_i && is_send && was_idle;

  assign next_shift    = shift_byte_q >> 1;
  assign high_dur      = shift_byte_q[0] ? dur(cfg_i.long_ticks) : dur(cfg_i.short_ticks);
  assign low_dur       = shift_byte_q[0] ? dur(cfg_i.short_ticks) : dur(cfg_i.long_ticks);
  assign next_high_dur = next_shift[0] ? dur(cfg_i.long_ticks) : dur(cfg_i.short_ticks);

  always_comb begin
    phase_d       = phase_q;
    tick_left_d   = tick_left_q;
    bit_index_d   = bit_index_q;
    shift_byte_d  = shift_byte_q;
    queue_count_d = queue_count_q;
    queue_head_d  = queue_head_q;
    if (is_send) begin
      if (was_idle) begin
        queue_count_d = seq_len;
        phase_d       = PH_WAIT;
        tick_left_d   = '0;
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_WAIT: begin
          if (!cfg_i.busy_wait_enable || !module_busy_i) begin
            if (queue_count_q == '0) begin
              phase_d     = PH_IDLE;
              tick_left_d = '0;
            end else begin
              shift_byte_d  = queue_q[queue_head_q];
              queue_head_d  = queue_head_q + QueueAw'(1);
              queue_count_d = queue_count_q - QueueCntW'(1);
              bit_index_d   = '0;
              phase_d       = PH_START_HIGH;
              tick_left_d   = dur(cfg_i.start_high_ticks);
            end
          end
        end
        PH_START_HIGH, PH_START_LOW, PH_BIT_HIGH, PH_BIT_LOW: begin
          if (tick_left_q > TickW'(1)) begin
            tick_left_d = tick_left_q - TickW'(1);
          end else begin
            unique case (phase_q)
              PH_START_HIGH: begin
                phase_d     = PH_START_LOW;
                tick_left_d = dur(cfg_i.start_low_ticks);
              end
              PH_START_LOW: begin
                phase_d     = PH_BIT_HIGH;
                tick_left_d = high_dur;
              end
              PH_BIT_HIGH: begin
                phase_d     = PH_BIT_LOW;
                tick_left_d = low_dur;
              end
              default: begin
                shift_byte_d = next_shift;
                if (bit_index_q == BitIdxW'(BitsPerByte - 1)) begin
                  // byte done: pop the next one or fall idle
                  if (queue_count_q == '0) begin
                    phase_d     = PH_IDLE;
                    tick_left_d = '0;
                  end else begin
                    shift_byte_d  = queue_q[queue_head_q];
                    queue_head_d  = queue_head_q + QueueAw'(1);
                    queue_count_d = queue_count_q - QueueCntW'(1);
                    bit_index_d   = '0;
                    phase_d       = PH_START_HIGH;
                    tick_left_d   = dur(cfg_i.start_high_ticks);
                  end
                end else begin
                  bit_index_d = bit_index_q + BitIdxW'(1);
                  phase_d     = PH_BIT_HIGH;
                  tick_left_d = next_high_dur;
                end
              end
            endcase
          end
        end
        default: begin
          phase_d     = PH_IDLE;
          tick_left_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      tick_left_q   <= '0;
      bit_index_q   <= '0;
      queue_count_q <= '0;
      queue_head_q  <= '0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      tick_left_q   <= tick_left_d;
      bit_index_q   <= bit_index_d;
      queue_count_q <= queue_count_d;
      queue_head_q  <= queue_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      shift_byte_q <= shift_byte_d;
    end
  end

  // entries are filled starting at the head slot
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      off[i] = QueueAw'(i) - queue_head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (do_enq && (QueueCntW'(off[i]) < seq_len)) begin
        queue_q[i] <= seq[off[i]];
      end
    end
  end

  assign res_o.line_level = !((phase_d == PH_START_LOW) || (phase_d == PH_BIT_LOW));
  assign res_o.idle       = (phase_d == PH_IDLE) && (queue_count_d == '0);
  assign res_o.rejected   = rejected;

endmodule

FILE: src/one_wire_pulse_width_sender_unit.sv
// one-wire pulse-width sender: drives a control wire that idles high and sends
// queued bytes as timed pulses, each byte a start pulse (high, then low) and
// eight bits lsb first, a one as long high + short low, a zero as short high +
// long low. operation 1 queues command_code, operation 2 queues 0x0a, the
// decimal digits of number (a value of 100 or more sends its quotient by ten
// as one byte) and command_code; a send request while not idle is dropped and
// flagged in rejected. operation 0 (and 3) is a tick, the only thing that
// advances time; with busy_wait_enable set the first byte waits for
// module_busy low. every accepted request gives exactly one result, with the
// line level after it. throughput is one request per clock: the state update
// is a single registered step, and a result register plus a one-entry skid
// register decouple the output side, so in_stall_o rises only when both are
// full. configuration registers take effect on the next request and should be
// written when idle.
module one_wire_pulse_width_sender_unit import owps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          command_code_i,
  input  logic [7:0]          number_i,
  input  logic                module_busy_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                line_level_o,
  output logic                idle_o,
  output logic                rejected_o
);

  owps_cfg_t    cfg_q;
  owps_result_t res;
  owps_result_t out_q, skid_q;
  logic         out_valid_q, skid_valid_q;
  logic         accept, out_fire;

  // configuration registers, unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_high_ticks <= START_HIGH_RST;
      cfg_q.start_low_ticks  <= START_LOW_RST;
      cfg_q.long_ticks       <= LONG_RST;
      cfg_q.short_ticks      <= SHORT_RST;
      cfg_q.busy_wait_enable <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_HIGH: cfg_q.start_high_ticks <= cfg_wdata_i;
        REG_START_LOW:  cfg_q.start_low_ticks  <= cfg_wdata_i;
        REG_LONG:       cfg_q.long_ticks       <= cfg_wdata_i;
        REG_SHORT:      cfg_q.short_ticks      <= cfg_wdata_i;
        REG_BUSY_WAIT:  cfg_q.busy_wait_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // stall only once the skid entry is holding a result
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  // sender state and byte queue
  owps_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .operation_i    (operation_i),
    .command_code_i (command_code_i),
    .number_i       (number_i),
    .module_busy_i  (module_busy_i),
    .cfg_i          (cfg_q),
    .res_o          (res)
  );

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_fire && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = out_q.line_level;
  assign idle_o       = out_q.idle;
  assign rejected_o   = out_q.rejected;

endmodule

FILE: verif/owps_wire_checker.sv
module owps_wire_checker import owps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          command_code_i,
  input  logic [7:0]          number_i,
  input  logic                module_busy_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                line_level_i,
  input  logic                idle_i,
  input  logic                rejected_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output logic                wire_idle_o
);

  owps_cfg_t          timing;
  owps_phase_e        ph;
  logic [TickW-1:0]   ticks_left;
  logic [BitIdxW-1:0] bit_pos;
  logic [7:0]         shifter;
  logic [7:0]         byte_fifo [QueueDepth];
  int unsigned        fifo_count;
  int unsigned        fifo_head;
  owps_result_t       expected_q [$];
  int unsigned        mismatches = 0;

  // a setting of zero still lasts one tick
  function automatic logic [TickW-1:0] ticks_for(input logic [TickW-1:0] setting);
    return (setting == '0) ? TickW'(1) : setting;
  endfunction

  // long for the high half of a one and the low half of a zero
  function automatic logic [TickW-1:0] half_bit(input logic high_half);
    return ticks_for((shifter[0] == high_half) ? timing.long_ticks : timing.short_ticks);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    if (fifo_count < QueueDepth) begin
      byte_fifo[(fifo_head + fifo_count) % QueueDepth] = b;
      fifo_count++;
    end
  endfunction

  function automatic void next_byte();
    if (fifo_count == 0) begin
      ph = PH_IDLE;
      ticks_left = '0;
    end else begin
      shifter = byte_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % QueueDepth;
      fifo_count--;
      bit_pos = '0;
      ph = PH_START_HIGH;
      ticks_left = ticks_for(timing.start_high_ticks);
    end
  endfunction

  function automatic void advance_tick(input logic busy);
    if (ph == PH_WAIT) begin
      if (!timing.busy_wait_enable || !busy) next_byte();
    end else if (ph != PH_IDLE) begin
      if (ticks_left > 1) begin
        ticks_left--;
      end else begin
        case (ph)
          PH_START_HIGH: begin
            ph = PH_START_LOW;
            ticks_left = ticks_for(timing.start_low_ticks);
          end
          PH_START_LOW: begin
            ph = PH_BIT_HIGH;
            ticks_left = half_bit(1'b1);
          end
          PH_BIT_HIGH: begin
            ph = PH_BIT_LOW;
            ticks_left = half_bit(1'b0);
          end
          default: begin
            shifter = shifter >> 1;
            if (bit_pos == BitIdxW'(BitsPerByte - 1)) begin
              next_byte();
            end else begin
              bit_pos++;
              ph = PH_BIT_HIGH;
              ticks_left = half_bit(1'b1);
            end
          end
        endcase
      end
    end
  endfunction

  function automatic owps_result_t wire_step(input logic [1:0] op, input logic [7:0] code,
                                             input logic [7:0] num, input logic busy);
    owps_result_t r;
    logic         was_idle;
    was_idle = (ph == PH_IDLE) && (fifo_count == 0);
    r.rejected = 1'b0;
    if (op == OP_SEND || op == OP_COMBINED) begin
      if (!was_idle) begin
        r.rejected = 1'b1;
      end else begin
        if (op == OP_SEND) begin
          queue_byte(code);
        end else begin
          queue_byte(LEAD_BYTE);
          if (num < 10) begin
            queue_byte(num);
          end else begin
            queue_byte(8'(num / 10));
            queue_byte(8'(num % 10));
          end
          queue_byte(code);
        end
        ph = PH_WAIT;
        ticks_left = '0;
      end
    end else begin
      advance_tick(busy);
    end
    r.line_level = !(ph == PH_START_LOW || ph == PH_BIT_LOW);
    r.idle = (ph == PH_IDLE) && (fifo_count == 0);
    return r;
  endfunction

  function automatic void report_failure(input string what, input owps_result_t want,
                                         input owps_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected line=%0b idle=%0b rejected=%0b, got line=%0b idle=%0b rejected=%0b",
               $time, what, want.line_level, want.idle, want.rejected,
               got.line_level, got.idle, got.rejected);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    owps_result_t got;
    owps_result_t want;
    if (!rst_ni) begin
      timing = '{START_HIGH_RST, START_LOW_RST, LONG_RST, SHORT_RST, 1'b1};
      ph = PH_IDLE;
      ticks_left = '0;
      bit_pos = '0;
      shifter = '0;
      fifo_count = 0;
      fifo_head = 0;
      expected_q.delete();
    end else begin
      // results first: a result seen at this edge belongs to an earlier request
      if (out_valid_i && !out_stall_i) begin
        got = '{line_level_i, idle_i, rejected_i};
        if (expected_q.size() == 0) begin
          report_failure("result with none expected", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.line_level !== want.line_level || got.idle !== want.idle ||
              got.rejected !== want.rejected) begin
            report_failure("result mismatch", want, got);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_START_HIGH: timing.start_high_ticks = cfg_wdata_i;
          REG_START_LOW:  timing.start_low_ticks  = cfg_wdata_i;
          REG_LONG:       timing.long_ticks       = cfg_wdata_i;
          REG_SHORT:      timing.short_ticks      = cfg_wdata_i;
          REG_BUSY_WAIT:  timing.busy_wait_enable = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(wire_step(operation_i, command_code_i, number_i, module_busy_i));
      end
    end
    fail_count_o = mismatches;
    pending_o = expected_q.size();
    wire_idle_o = (ph == PH_IDLE) && (fifo_count == 0);
  end

endmodule

FILE: verif/one_wire_pulse_width_sender_unit_tb.sv
module one_wire_pulse_width_sender_unit_tb;
  import owps_pkg::*;

  // operation code 3 is unused and behaves like a tick
  localparam logic [1:0] OP_SPARE = 2'd3;

  // register indexes past the last register, writes there must be ignored
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_C = 3'd7;

  // length of the long receiver hold-off, in cycles
  localparam int unsigned RX_HOLD_CYCLES = 120;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_we       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index    = '0;
  logic [CfgDataW-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [1:0]          operation    = OP_TICK;
  logic [7:0]          command_code = '0;
  logic [7:0]          number       = '0;
  logic                module_busy  = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                line_level;
  logic                idle;
  logic                rejected;

  // percentages of cycles in which each side holds back
  int unsigned tx_idle_pct   = 26;
  int unsigned rx_idle_pct   = 82;
  bit          hold_off_req  = 1'b0;

  // from the checker
  int unsigned fail_count;
  int unsigned pending;
  logic        wire_idle;

  // 12 time unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  one_wire_pulse_width_sender_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .command_code_i (command_code),
    .number_i       (number),
    .module_busy_i  (module_busy),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .line_level_o   (line_level),
    .idle_o         (idle),
    .rejected_o     (rejected)
  );

  owps_wire_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .command_code_i (command_code),
    .number_i       (number),
    .module_busy_i  (module_busy),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .line_level_i   (line_level),
    .idle_i         (idle),
    .rejected_i     (rejected),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .wire_idle_o    (wire_idle)
  );

  // result side: random stalls, plus one long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // keep stalling so the result buffers fill and the request side backs up
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // called at a falling edge; returns at the rising edge that takes the request
  task automatic offer(input logic [1:0] op, input logic [7:0] code, input logic [7:0] num,
                       input logic busy);
    // random gaps before the request
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    command_code <= code;
    number       <= num;
    module_busy  <= busy;
    // payload stays put while stalled
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_now(input logic [1:0] op, input logic [7:0] code, input logic [7:0] num,
                          input logic busy);
    @(negedge clk);
    offer(op, code, num, busy);
  endtask

  // tick with busy low until the predicted wire is idle again
  task automatic drain();
    @(negedge clk);
    while (!wire_idle) begin
      offer(OP_TICK, 8'($urandom), 8'($urandom), 1'b0);
      @(negedge clk);
    end
  endtask

  // stop requesting and wait until every result is back, plus the output latency
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // new timing, only with the wire quiet and nothing in flight
  task automatic retime(input logic [CfgDataW-1:0] start_high, input logic [CfgDataW-1:0] start_low,
                        input logic [CfgDataW-1:0] long_half, input logic [CfgDataW-1:0] short_half,
                        input logic [CfgDataW-1:0] busy_wait);
    drain();
    settle();
    set_reg(REG_START_HIGH, start_high);
    set_reg(REG_START_LOW, start_low);
    set_reg(REG_LONG, long_half);
    set_reg(REG_SHORT, short_half);
    set_reg(REG_BUSY_WAIT, busy_wait);
  endtask

  task automatic send_and_drain(input logic [1:0] op, input logic [7:0] code,
                                input logic [7:0] num);
    send_now(op, code, num, 1'b1);
    drain();
  endtask

  // mostly well-formed sends into an idle wire, ticks to move them along,
  // and now and then a request that lands while busy
  task automatic offer_random();
    logic [1:0]  op;
    logic [7:0]  num;
    int unsigned pick;
    @(negedge clk);
    pick = $urandom_range(99);
    case ($urandom_range(2))
      0:       num = 8'($urandom_range(9));
      1:       num = 8'($urandom_range(99, 10));
      default: num = 8'($urandom_range(255, 100));
    endcase
    if (wire_idle) begin
      op = (pick < 35) ? (pick[0] ? OP_SEND : OP_COMBINED) : ((pick < 40) ? OP_SPARE : OP_TICK);
    end else begin
      op = (pick < 6) ? (pick[0] ? OP_SEND : OP_COMBINED) : ((pick < 10) ? OP_SPARE : OP_TICK);
    end
    offer(op, 8'($urandom), num, $urandom_range(99) < 30);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) offer_random();
  endtask

  // safety net against a hung handshake
  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset timing: ticks and the spare code while idle
    send_now(OP_TICK, 8'hff, 8'hff, 1'b1);
    send_now(OP_SPARE, 8'h00, 8'h00, 1'b0);
    // send held by module busy, requests while active get rejected,
    // then the spare code ticks it loose
    send_now(OP_SEND, 8'ha5, 8'h5a, 1'b1);
    send_now(OP_TICK, 8'h00, 8'h00, 1'b1);
    send_now(OP_TICK, 8'hff, 8'hff, 1'b1);
    send_now(OP_SEND, 8'h3c, 8'h00, 1'b0);
    send_now(OP_COMBINED, 8'h12, 8'd42, 1'b0);
    send_now(OP_SPARE, 8'h00, 8'hff, 1'b0);
    drain();

    // short timing, zero start low, busy wait off
    retime(10'd1, 10'd0, 10'd2, 10'd1, 10'd0);
    // writes past the last register do nothing
    set_reg(REG_SPARE_A, '1);
    set_reg(REG_SPARE_B, '0);
    set_reg(REG_SPARE_C, 10'h155);

    // byte extremes and every digit split of a combined send
    send_and_drain(OP_SEND, 8'h00, 8'hff);
    send_and_drain(OP_SEND, 8'hff, 8'h00);
    send_and_drain(OP_COMBINED, 8'hff, 8'd0);
    send_and_drain(OP_COMBINED, 8'h00, 8'd9);
    send_and_drain(OP_COMBINED, 8'hc3, 8'd10);
    send_and_drain(OP_COMBINED, 8'h7e, 8'd99);
    send_and_drain(OP_COMBINED, 8'h01, 8'd100);
    send_and_drain(OP_COMBINED, 8'h80, 8'd255);

    // random, sender mostly busy and receiver mostly stalling
    retime(10'($urandom_range(3, 1)), 10'($urandom_range(3, 1)), 10'($urandom_range(3, 1)),
           10'($urandom_range(3, 1)), 10'd1);
    hold_off_req = 1'b1;
    run_random(200);

    // roles swapped, zero durations allowed, busy wait off
    tx_idle_pct = 82;
    rx_idle_pct = 26;
    retime(10'($urandom_range(4)), 10'($urandom_range(4)), 10'($urandom_range(4)),
           10'($urandom_range(4)), 10'd0);
    hold_off_req = 1'b1;
    run_random(200);

    // no idling from here on
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // long start low that uses the top bit of the tick counter, one byte
    retime(10'h001, 10'h200, 10'h002, 10'h001, 10'h3ff);
    send_now(OP_SEND, 8'h5a, 8'ha5, 1'b0);
    drain();

    // every duration zero, busy wait off through an even data word
    retime(10'h000, 10'h000, 10'h000, 10'h000, 10'h3fe);
    send_now(OP_COMBINED, 8'hc6, 8'd137, 1'b1);
    drain();

    // back-to-back random, with one pause until all results are in
    retime(10'($urandom_range(6, 1)), 10'($urandom_range(6, 1)), 10'($urandom_range(6, 1)),
           10'($urandom_range(6, 1)), 10'd1);
    run_random(100);
    settle();
    run_random(100);

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
